/* design/usart_register_model_top_assert.svh */
// -----------------------------------------------------------------------------
// usart register model assertion macros
// concurrent checks, compiled out for synthesis
// -----------------------------------------------------------------------------
`ifndef USART_REGISTER_MODEL_TOP_ASSERT_SVH
`define USART_REGISTER_MODEL_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define URM_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// antecedent implies consequent in the next cycle
`define URM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define URM_ASSERT_SAME(lbl, ante, cons, msg)
`define URM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/urm_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// urm_pkg
// types, codes and state helpers of the 8251-style usart register model
// -----------------------------------------------------------------------------
package urm_pkg;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_IDLE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_MODE    = 2'd0,
      PH_SYNC1   = 2'd1,
      PH_SYNC2   = 2'd2,
      PH_COMMAND = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      OFF_DATA      = 2'd0,
      OFF_CONTROL   = 2'd1,
      OFF_RX_VECTOR = 2'd2,
      OFF_TX_VECTOR = 2'd3
   } offset_type;

   typedef enum logic {
      CSR_ENABLED      = 1'b0,
      CSR_BASE_ADDRESS = 1'b1
   } csr_index_type;

   // status bit positions
   localparam int ST_TXRDY   = 0;
   localparam int ST_RXRDY   = 1;
   localparam int ST_TXEMPTY = 2;
   localparam int ST_PE      = 3;
   localparam int ST_OE      = 4;
   localparam int ST_FE      = 5;
   localparam int STATUS_W   = 6;

   // command bit positions
   localparam int CMD_TXEN = 0;
   localparam int CMD_RXEN = 2;
   localparam int CMD_ER   = 4;
   localparam int CMD_RTS  = 5;
   localparam int CMD_IR   = 6;

   // low address bits that select a register in the window
   localparam int OFFSET_W = 2;
   localparam int ADDR_W   = 16;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        rx_available;
      logic [7:0]  rx_byte;
      logic        tx_space;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rx_taken;
      logic [7:0] rx_vector_active;
      logic [7:0] tx_vector_active;
   } rsp_item_type;

   typedef struct packed {
      csr_index_type index;
      logic [15:0]   data;
   } csr_item_type;

   // input register contents handed to the core
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

   // only the command bits that matter are kept
   typedef struct packed {
      logic rts;
      logic rxen;
      logic txen;
   } cmd_type;

   typedef struct packed {
      phase_type           phase;
      logic [STATUS_W-1:0] status;
      cmd_type             cmd;
      logic [7:0]          tx_hold;
      logic [7:0]          rx_hold;
      logic [7:0]          rx_code;
      logic [7:0]          tx_code;
      logic [7:0]          rx_live;
      logic [7:0]          tx_live;
   } state_type;

   localparam logic [STATUS_W-1:0] STATUS_RESET =
      STATUS_W'((1 << ST_TXRDY) | (1 << ST_TXEMPTY));

   localparam state_type STATE_RESET = '{
      phase:   PH_MODE,
      status:  STATUS_RESET,
      cmd:     '0,
      tx_hold: '0,
      rx_hold: '0,
      rx_code: '0,
      tx_code: '0,
      rx_live: '0,
      tx_live: '0
   };

   // receive ready moves; live vector follows the edge when a code is set
   function automatic state_type rx_ready_set(state_type s, logic on);
      state_type r;
      r = s;
      if ((s.status[ST_RXRDY] != on) && (s.rx_code != '0)) begin
         r.rx_live = on ? s.rx_code : '0;
      end
      r.status[ST_RXRDY] = on;
      return r;
   endfunction

   // txrdy and txempty always move together
   function automatic state_type tx_ready_set(state_type s, logic on);
      state_type r;
      r = s;
      if ((s.status[ST_TXRDY] != on) && (s.tx_code != '0)) begin
         r.tx_live = on ? s.tx_code : '0;
      end
      r.status[ST_TXRDY]   = on;
      r.status[ST_TXEMPTY] = on;
      return r;
   endfunction

endpackage

/* design/urm_chan_if.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// urm_chan_if
// valid/ready channel carrying one payload beat
// -----------------------------------------------------------------------------
interface urm_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type item;

   modport source (output valid, output item, input ready);
   modport sink (input valid, input item, output ready);
endinterface

/* design/urm_in_stage.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// urm_in_stage
// input register; takes a new beat whenever it is empty or draining
// -----------------------------------------------------------------------------
module urm_in_stage (
   input  logic              clock,
   input  logic              reset,
   urm_chan_if.sink          req_chan,
   input  logic              advance,
   output urm_pkg::stage_type stage
);
   logic                  valid_ff;
   logic                  valid_in;
   urm_pkg::req_item_type item_ff;
   logic                  take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign valid_in       = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_chan.item;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;
endmodule

/* design/urm_core.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// urm_core
// register file of the usart and the per-beat update and result logic
// -----------------------------------------------------------------------------
module urm_core (
   input  logic                  clock,
   input  logic                  reset,
   input  urm_pkg::stage_type    stage,
   input  logic                  advance,
   input  logic                  cfg_write,
   input  urm_pkg::csr_item_type cfg_item,
   output urm_pkg::rsp_item_type result
);
   localparam int BASE_W = urm_pkg::ADDR_W - urm_pkg::OFFSET_W;

   urm_pkg::state_type    state_ff;
   urm_pkg::state_type    state_in;
   logic                  enabled_ff;
   logic [BASE_W-1:0]     base_ff;
   urm_pkg::req_item_type item;
   urm_pkg::offset_type   offset;
   logic                  hit;
   logic [7:0]            wd;

   assign item   = stage.item;
   assign wd     = item.write_data;
   assign offset = urm_pkg::offset_type'(item.address[urm_pkg::OFFSET_W-1:0]);
   assign hit    = (item.address[urm_pkg::ADDR_W-1:urm_pkg::OFFSET_W] == base_ff);

   always_comb begin
      state_in = state_ff;
      result   = '0;
      case (urm_pkg::kind_type'(item.kind))
         urm_pkg::KIND_READ: begin
            if (hit) begin
               case (offset)
                  urm_pkg::OFF_DATA: begin
                     state_in         = urm_pkg::rx_ready_set(state_in, 1'b0);
                     result.read_data = state_ff.rx_hold;
                  end
                  urm_pkg::OFF_CONTROL: begin
                     result.read_data = {{(8 - urm_pkg::STATUS_W){1'b0}}, state_ff.status};
                  end
                  urm_pkg::OFF_RX_VECTOR: result.read_data = state_ff.rx_code;
                  default:                result.read_data = state_ff.tx_code;
               endcase
            end
         end
         urm_pkg::KIND_WRITE: begin
            if (hit) begin
               case (offset)
                  urm_pkg::OFF_DATA: begin
                     state_in.tx_hold = wd;
                     state_in         = urm_pkg::tx_ready_set(state_in, 1'b0);
                  end
                  urm_pkg::OFF_CONTROL: begin
                     case (state_ff.phase)
                        urm_pkg::PH_COMMAND: begin
                           // internal reset first, then error clear and new command
                           if (wd[urm_pkg::CMD_IR]) begin
                              state_in = urm_pkg::STATE_RESET;
                           end
                           if (wd[urm_pkg::CMD_ER]) begin
                              state_in.status[urm_pkg::ST_PE] = 1'b0;
                              state_in.status[urm_pkg::ST_OE] = 1'b0;
                              state_in.status[urm_pkg::ST_FE] = 1'b0;
                           end
                           state_in.cmd.rts  = wd[urm_pkg::CMD_RTS];
                           state_in.cmd.rxen = wd[urm_pkg::CMD_RXEN];
                           state_in.cmd.txen = wd[urm_pkg::CMD_TXEN];
                           state_in = urm_pkg::tx_ready_set(state_in, wd[urm_pkg::CMD_TXEN]);
                        end
                        urm_pkg::PH_MODE: begin
                           // synchronous mode brings two sync characters
                           state_in.phase = (wd[1:0] == 2'b00) ? urm_pkg::PH_SYNC1
                                                               : urm_pkg::PH_COMMAND;
                        end
                        urm_pkg::PH_SYNC1: state_in.phase = urm_pkg::PH_SYNC2;
                        default:           state_in.phase = urm_pkg::PH_COMMAND;
                     endcase
                  end
                  urm_pkg::OFF_RX_VECTOR: begin
                     state_in.rx_code = wd;
                     if (wd == '0) begin
                        state_in.rx_live = '0;
                     end else if (state_ff.cmd.rxen && state_ff.status[urm_pkg::ST_RXRDY]) begin
                        state_in.rx_live = wd;
                     end
                  end
                  default: begin
                     state_in.tx_code = wd;
                     if (wd == '0) begin
                        state_in.tx_live = '0;
                     end else if (state_ff.cmd.txen && state_ff.status[urm_pkg::ST_TXRDY]) begin
                        state_in.tx_live = wd;
                     end
                  end
               endcase
            end
         end
         urm_pkg::KIND_TICK: begin
            if (enabled_ff) begin
               if (state_ff.cmd.rxen && state_ff.cmd.rts && item.rx_available) begin
                  state_in.rx_hold = item.rx_byte;
                  // a byte still pending is overrun
                  if (state_ff.status[urm_pkg::ST_RXRDY]) begin
                     state_in.status[urm_pkg::ST_OE] = 1'b1;
                  end
                  state_in        = urm_pkg::rx_ready_set(state_in, 1'b1);
                  result.rx_taken = 1'b1;
               end
               if (state_ff.cmd.txen && item.tx_space && !state_ff.status[urm_pkg::ST_TXRDY]) begin
                  result.tx_valid = 1'b1;
                  result.tx_byte  = state_ff.tx_hold;
                  state_in        = urm_pkg::tx_ready_set(state_in, 1'b1);
               end
            end
         end
         default: ;
      endcase
      result.rx_vector_active = state_in.rx_live;
      result.tx_vector_active = state_in.tx_live;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= urm_pkg::STATE_RESET;
         enabled_ff <= 1'b0;
         base_ff    <= '0;
      end else if (cfg_write) begin
         // any register write also resets the usart state
         state_ff <= urm_pkg::STATE_RESET;
         case (cfg_item.index)
            urm_pkg::CSR_ENABLED:      enabled_ff <= cfg_item.data[0];
            urm_pkg::CSR_BASE_ADDRESS: base_ff <= cfg_item.data[urm_pkg::ADDR_W-1:urm_pkg::OFFSET_W];
            default: ;
         endcase
      end else if (advance) begin
         state_ff <= state_in;
      end
   end
endmodule

/* design/usart_register_model_top.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// usart_register_model_top
// 8251-style usart register model: bus reads, bus writes and service ticks
// -----------------------------------------------------------------------------
// channel    dir  payload
// req_chan   in   kind, address, write_data, rx_available, rx_byte, tx_space
// rsp_chan   out  read_data, tx_valid, tx_byte, rx_taken, rx/tx vector active
// csr_chan   in   index (0 enabled, 1 base address), data
//
// one beat per cycle while the result is not stalled; each request beat passes
// through the input register, then state update and the result register
// reset is synchronous; the csr channel is always ready, each write resets
// the usart state
// a stalled result holds in the output register while one more request waits
// in the input register
// -----------------------------------------------------------------------------
`include "usart_register_model_top_assert.svh"

module usart_register_model_top (
   input logic      clock,
   input logic      reset,
   urm_chan_if.sink   req_chan,
   urm_chan_if.source rsp_chan,
   urm_chan_if.sink   csr_chan
);
   urm_pkg::stage_type    stage;
   urm_pkg::rsp_item_type result;
   urm_pkg::rsp_item_type out_item_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic                  advance;
   logic                  cfg_write;

   assign advance      = stage.valid && (!out_valid_ff || rsp_chan.ready);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   assign csr_chan.ready = 1'b1;
   assign cfg_write      = csr_chan.valid;

   urm_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .stage    (stage)
   );

   urm_core u_core (
      .clock     (clock),
      .reset     (reset),
      .stage     (stage),
      .advance   (advance),
      .cfg_write (cfg_write),
      .cfg_item  (csr_chan.item),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.item  = out_item_ff;

   `URM_ASSERT_NEXT(a_req_lands, req_chan.valid && req_chan.ready, stage.valid, "accepted request beat not held in input register")
   `URM_ASSERT_NEXT(a_rsp_holds, out_valid_ff && !rsp_chan.ready, out_valid_ff && $stable(out_item_ff), "stalled result lost or changed")
   `URM_ASSERT_SAME(a_tx_quiet, out_valid_ff && !out_item_ff.tx_valid, out_item_ff.tx_byte == 8'd0, "tx byte nonzero without tx valid")
   `URM_ASSERT_NEXT(a_stage_holds, stage.valid && !advance, stage.valid, "stalled request dropped")
endmodule
